FILE: hw/rtl/lfrs_pkg.sv
`default_nettype none

package lfrs_pkg;

	// Opcodes of an incoming item.
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_DRAW  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// Chip select codes.
	localparam logic [1:0] SEL_BOTH   = 2'd0;
	localparam logic [1:0] SEL_FIRST  = 2'd1;
	localparam logic [1:0] SEL_SECOND = 2'd2;

	// Panel commands.
	localparam logic [7:0] CMD_SET_PAGE   = 8'hB8;
	localparam logic [7:0] CMD_SET_COLUMN = 8'h40;

	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] pixel_x;
		logic [6:0] pixel_y;
		logic       pixel_on;
	} cmd_item_t;

	typedef struct packed {
		logic [7:0] bus_byte;
		logic       data_mode;
		logic [1:0] chip_select;
	} bus_item_t;

	typedef enum logic [1:0] {
		K_TICK,
		K_DRAW,
		K_CLEAR
	} op_kind_t;

	// One classified item waiting for the back end.
	typedef struct packed {
		op_kind_t   kind;
		logic [7:0] col;
		logic [2:0] page;
		logic [2:0] bitpos;
		logic       on;
	} q_entry_t;

	typedef struct packed {
		logic init_busy;
	} back_status_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_DRAW_WAIT,
		BK_TICK_WAIT,
		BK_CLEAR
	} back_state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lcd_framebuffer_refresh_scanner.sv
`default_nettype none

// Channel | Direction | Payload              | Handshake
// cmd     | in        | lfrs_pkg::cmd_item_t | cmd_valid, cmd_stall
// bus     | out       | lfrs_pkg::bus_item_t | bus_valid, bus_stall
//
// A data-phase tick reads the store in BK_IDLE and loads the result in
// BK_TICK_WAIT; a set-page or set-column tick loads it in BK_IDLE. A draw reads
// a store byte in BK_IDLE and writes it in BK_DRAW_WAIT, through the store's
// separate read and write ports. A clear writes all DEPTH store bytes, one per
// cycle (DEPTH is 1024 with the default parameters); after reset the same sweep
// runs with cmd_stall high throughout. Items pass through a two-entry queue, so
// the front accepts until it is full while the back waits on a stalled result.

module lcd_framebuffer_refresh_scanner #(
	parameter int COLUMNS_PER_CHIP = 64,
	parameter int CHIP_COUNT       = 2,
	parameter int PAGE_COUNT       = 8
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   cmd_valid,
	output logic                  cmd_stall,
	input  wire lfrs_pkg::cmd_item_t cmd,
	output logic                  bus_valid,
	input  wire                   bus_stall,
	output lfrs_pkg::bus_item_t   bus
);

	// Front to queue.
	logic                   q_push;
	lfrs_pkg::q_entry_t     q_push_entry;
	logic                   q_full;

	// Queue to back.
	logic                   q_head_valid;
	lfrs_pkg::q_entry_t     q_head;
	logic                   q_pop;

	// The back reports while its start-up sweep is still running.
	lfrs_pkg::back_status_t status;

	// The front decodes each item, drops out-of-range draws and unused opcodes,
	// and queues the rest in arrival order.
	lfrs_front #(
		.COLUMNS_PER_CHIP(COLUMNS_PER_CHIP),
		.CHIP_COUNT      (CHIP_COUNT),
		.PAGE_COUNT      (PAGE_COUNT)
	) u_front (
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.q_full    (q_full),
		.status    (status),
		.q_push    (q_push),
		.q_entry   (q_push_entry)
	);

	lfrs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_push_entry),
		.full       (q_full),
		.head_valid (q_head_valid),
		.head       (q_head),
		.pop        (q_pop)
	);

	// The back owns the frame store and the scan counters, and holds each
	// result in an output register until the bus side takes it.
	lfrs_back #(
		.COLUMNS_PER_CHIP(COLUMNS_PER_CHIP),
		.CHIP_COUNT      (CHIP_COUNT),
		.PAGE_COUNT      (PAGE_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_head_valid),
		.q_entry   (q_head),
		.q_pop     (q_pop),
		.status    (status),
		.bus_valid (bus_valid),
		.bus_stall (bus_stall),
		.bus       (bus)
	);

endmodule

`default_nettype wire

FILE: hw/rtl/lfrs_ram.sv
`default_nettype none

module lfrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire                       clk,
	input  wire                       we,
	input  wire [$clog2(DEPTH)-1:0]   waddr,
	input  wire [WIDTH-1:0]           wdata,
	input  wire                       re,
	input  wire [$clog2(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/lfrs_front.sv
`default_nettype none

module lfrs_front #(
	parameter int COLUMNS_PER_CHIP = 64,
	parameter int CHIP_COUNT       = 2,
	parameter int PAGE_COUNT       = 8
) (
	input  wire                      cmd_valid,
	output logic                     cmd_stall,
	input  wire lfrs_pkg::cmd_item_t cmd,
	input  wire                      q_full,
	input  wire lfrs_pkg::back_status_t status,
	output logic                     q_push,
	output lfrs_pkg::q_entry_t       q_entry
);

	localparam int TOTAL_COLUMNS = COLUMNS_PER_CHIP * CHIP_COUNT;
	localparam int ROW_COUNT     = 8 * PAGE_COUNT;

	logic in_range;
	logic keep;

	assign cmd_stall = q_full || status.init_busy;
	assign in_range  = ({1'b0, cmd.pixel_x} < 9'(TOTAL_COLUMNS)) &&
	                   (cmd.pixel_y < 7'(ROW_COUNT));

	always_comb begin
		q_entry.col    = cmd.pixel_x;
		q_entry.page   = cmd.pixel_y[5:3];
		q_entry.bitpos = cmd.pixel_y[2:0];
		q_entry.on     = cmd.pixel_on;
		q_entry.kind   = lfrs_pkg::K_TICK;
		keep           = 1'b0;
		case (cmd.opcode)
			lfrs_pkg::OP_TICK: begin
				q_entry.kind = lfrs_pkg::K_TICK;
				keep         = 1'b1;
			end
			lfrs_pkg::OP_DRAW: begin
				// Pixels outside the panel are dropped here.
				q_entry.kind = lfrs_pkg::K_DRAW;
				keep         = in_range;
			end
			lfrs_pkg::OP_CLEAR: begin
				q_entry.kind = lfrs_pkg::K_CLEAR;
				keep         = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign q_push = cmd_valid && !cmd_stall && keep;

endmodule

`default_nettype wire

FILE: hw/rtl/lfrs_queue.sv
`default_nettype none

module lfrs_queue (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push,
	input  wire lfrs_pkg::q_entry_t push_entry,
	output logic                  full,
	output logic                  head_valid,
	output lfrs_pkg::q_entry_t    head,
	input  wire                   pop
);

	localparam int PTR_W = $clog2(lfrs_pkg::QUEUE_DEPTH);

	lfrs_pkg::q_entry_t slot_q [lfrs_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [PTR_W:0]     count_q;
	logic               do_push;
	logic               do_pop;

	assign full       = (count_q == (PTR_W+1)'(lfrs_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (PTR_W+1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (PTR_W+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/lfrs_back.sv
`default_nettype none

module lfrs_back #(
	parameter int COLUMNS_PER_CHIP = 64,
	parameter int CHIP_COUNT       = 2,
	parameter int PAGE_COUNT       = 8
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      q_valid,
	input  wire lfrs_pkg::q_entry_t  q_entry,
	output logic                     q_pop,
	output lfrs_pkg::back_status_t   status,
	output logic                     bus_valid,
	input  wire                      bus_stall,
	output lfrs_pkg::bus_item_t      bus
);

	localparam int TOTAL_COLUMNS = COLUMNS_PER_CHIP * CHIP_COUNT;
	localparam int CW            = $clog2(TOTAL_COLUMNS);
	localparam int PW            = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
	localparam int DEPTH         = TOTAL_COLUMNS * (2 ** PW);
	localparam int AW            = CW + PW;
	localparam int PHW           = $clog2(COLUMNS_PER_CHIP + 2);
	localparam logic [PHW-1:0] PH_PAGE = PHW'(COLUMNS_PER_CHIP);
	localparam logic [PHW-1:0] PH_ADDR = PHW'(COLUMNS_PER_CHIP + 1);

	lfrs_pkg::back_state_t state_q, state_d;

	logic [PW-1:0]  page_q, page_d;
	logic [PHW-1:0] phase_q, phase_d;
	logic           chip_q, chip_d;
	logic [1:0]     sel_q, sel_d;
	logic           mode_q, mode_d;
	logic [AW-1:0]  clr_q, clr_d;
	logic           init_q, init_d;

	logic [AW-1:0]  draw_addr_q;
	logic [2:0]     draw_bit_q;
	logic           draw_on_q;
	logic           draw_load;

	logic                  out_valid_q;
	lfrs_pkg::bus_item_t   out_item_q;
	lfrs_pkg::bus_item_t   out_item_d;
	logic                  load_out;
	logic                  out_free;

	logic           ram_we;
	logic [AW-1:0]  ram_waddr;
	logic [7:0]     ram_wdata;
	logic           ram_re;
	logic [AW-1:0]  ram_raddr;
	logic [7:0]     ram_rdata;

	// Scan step values for a tick.
	logic           is_page;
	logic           is_addr;
	logic [PW:0]    page_inc;
	logic           page_wrap;
	logic           chip_nx;
	logic [PW-1:0]  page_t;
	logic           chip_t;
	logic [1:0]     sel_t;
	logic           mode_t;
	logic [CW-1:0]  scan_col;
	logic [7:0]     draw_mask;
	logic [AW-1:0]  entry_addr;

	assign out_free   = !out_valid_q || !bus_stall;
	assign is_page    = (phase_q == PH_PAGE);
	assign is_addr    = (phase_q == PH_ADDR);
	assign page_inc   = {1'b0, page_q} + (PW+1)'(1);
	assign page_wrap  = (page_inc >= (PW+1)'(PAGE_COUNT));
	assign chip_nx    = (CHIP_COUNT > 1) ? ~chip_q : 1'b0;
	assign page_t     = is_page ? (page_wrap ? '0 : page_inc[PW-1:0]) : page_q;
	assign chip_t     = (is_page && page_wrap) ? chip_nx : chip_q;
	assign sel_t      = (is_page && page_wrap) ?
	                    (chip_nx ? lfrs_pkg::SEL_SECOND : lfrs_pkg::SEL_FIRST) : sel_q;
	assign mode_t     = is_page ? 1'b0 : mode_q;
	assign scan_col   = chip_q ? (CW'(COLUMNS_PER_CHIP) + CW'(phase_q)) : CW'(phase_q);
	assign entry_addr = {q_entry.col[CW-1:0], q_entry.page[PW-1:0]};
	assign draw_mask  = 8'(1) << draw_bit_q;

	assign status.init_busy = init_q;

	always_comb begin
		state_d    = state_q;
		page_d     = page_q;
		phase_d    = phase_q;
		chip_d     = chip_q;
		sel_d      = sel_q;
		mode_d     = mode_q;
		clr_d      = clr_q;
		init_d     = init_q;
		q_pop      = 1'b0;
		draw_load  = 1'b0;
		load_out   = 1'b0;
		out_item_d = out_item_q;
		ram_we     = 1'b0;
		ram_waddr  = clr_q;
		ram_wdata  = '0;
		ram_re     = 1'b0;
		ram_raddr  = entry_addr;
		case (state_q)
			lfrs_pkg::BK_IDLE: begin
				if (q_valid) begin
					case (q_entry.kind)
						lfrs_pkg::K_TICK: begin
							if (out_free) begin
								q_pop   = 1'b1;
								page_d  = page_t;
								chip_d  = chip_t;
								sel_d   = sel_t;
								phase_d = is_addr ? '0 : phase_q + PHW'(1);
								mode_d  = is_addr ? 1'b1 : mode_t;
								if (is_page || is_addr) begin
									load_out   = 1'b1;
									out_item_d.bus_byte    = is_page ?
										(lfrs_pkg::CMD_SET_PAGE + 8'(page_t)) :
										lfrs_pkg::CMD_SET_COLUMN;
									out_item_d.data_mode   = mode_t;
									out_item_d.chip_select = sel_t;
								end else begin
									ram_re    = 1'b1;
									ram_raddr = {scan_col, page_q};
									state_d   = lfrs_pkg::BK_TICK_WAIT;
								end
							end
						end
						lfrs_pkg::K_DRAW: begin
							q_pop     = 1'b1;
							draw_load = 1'b1;
							ram_re    = 1'b1;
							state_d   = lfrs_pkg::BK_DRAW_WAIT;
						end
						lfrs_pkg::K_CLEAR: begin
							q_pop   = 1'b1;
							clr_d   = '0;
							state_d = lfrs_pkg::BK_CLEAR;
						end
						default: begin
							q_pop = 1'b1;
						end
					endcase
				end
			end
			lfrs_pkg::BK_DRAW_WAIT: begin
				ram_we    = 1'b1;
				ram_waddr = draw_addr_q;
				ram_wdata = draw_on_q ? (ram_rdata | draw_mask) : (ram_rdata & ~draw_mask);
				state_d   = lfrs_pkg::BK_IDLE;
			end
			lfrs_pkg::BK_TICK_WAIT: begin
				// A data phase leaves mode and select untouched.
				load_out   = 1'b1;
				out_item_d.bus_byte    = ram_rdata;
				out_item_d.data_mode   = mode_q;
				out_item_d.chip_select = sel_q;
				state_d    = lfrs_pkg::BK_IDLE;
			end
			lfrs_pkg::BK_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
				if (clr_q == AW'(DEPTH - 1)) begin
					init_d  = 1'b0;
					state_d = lfrs_pkg::BK_IDLE;
				end else begin
					clr_d = clr_q + AW'(1);
				end
			end
			default: begin
				state_d = lfrs_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lfrs_pkg::BK_CLEAR;
			page_q      <= '0;
			phase_q     <= '0;
			chip_q      <= 1'b0;
			sel_q       <= lfrs_pkg::SEL_BOTH;
			mode_q      <= 1'b1;
			clr_q       <= '0;
			init_q      <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			page_q  <= page_d;
			phase_q <= phase_d;
			chip_q  <= chip_d;
			sel_q   <= sel_d;
			mode_q  <= mode_d;
			clr_q   <= clr_d;
			init_q  <= init_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!bus_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_item_q <= out_item_d;
		end
		if (draw_load) begin
			draw_addr_q <= entry_addr;
			draw_bit_q  <= q_entry.bitpos;
			draw_on_q   <= q_entry.on;
		end
	end

	assign bus_valid = out_valid_q;
	assign bus       = out_item_q;

	lfrs_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> out_free)
		else $error("result loaded over an untaken result");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("store read and written in one cycle");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= PH_ADDR)
		else $error("scan phase out of range");

	a_tick_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lfrs_pkg::BK_TICK_WAIT) |=> out_valid_q)
		else $error("data tick gave no result");

	a_init_only_clear: assert property (@(posedge clk) disable iff (!arst_n)
		init_q |-> (state_q == lfrs_pkg::BK_CLEAR))
		else $error("start-up sweep left early");

endmodule

`default_nettype wire
